[rtl/core/dpo_pkg.sv]
// ----------------------------------------------------------------------------
// dpo_pkg
// shared types, constants and calendar helpers for the date overlap unit
// ----------------------------------------------------------------------------
package dpo_pkg;

  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned NumW    = 21;  // day number, max about 1.1e6
  localparam int unsigned CntW    = 20;
  localparam int unsigned QuotW   = 6;   // year / 100 for a 12 bit year
  localparam int unsigned NDates  = 4;

  localparam int unsigned QDepth  = 4;
  localparam int unsigned QAw     = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [YearW-1:0]  YearMin  = YearW'(1001);
  localparam logic [YearW-1:0]  YearMax  = YearW'(2999);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

  // reciprocal for / 100, exact for any 12 bit value
  localparam int unsigned Div100Mul = 1311;
  localparam int unsigned Div100Sh  = 17;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef logic [NumW-1:0] day_num_t;

  typedef struct packed {
    logic                  err;
    day_num_t [NDates-1:0] num;   // a start, a end, b start, b end
  } q_entry_t;

  function automatic logic [QuotW-1:0] div100(input logic [YearW-1:0] v);
    logic [YearW+10:0] p;
    p = (YearW+11)'(v) * (YearW+11)'(Div100Mul);
    return QuotW'(p >> Div100Sh);
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y,
                                   input logic [QuotW-1:0] q);
    logic [YearW-1:0] c;
    c = YearW'(q) * YearW'(100);
    return (y[1:0] == 2'b00) && ((y != c) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = DayW'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    r = DayW'(30);
      4'd2:                                       r = leap ? DayW'(29) : DayW'(28);
      default:                                    r = DayW'(0);
    endcase
    return r;
  endfunction

  // days before the month in a year that starts in march
  function automatic logic [8:0] doy_offset(input logic [MonthW-1:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/dpo_front.sv]
// ----------------------------------------------------------------------------
// dpo_front
// two stage date decoder: checks each date and turns it into a day number
// ----------------------------------------------------------------------------
module dpo_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  dpo_pkg::date_t [dpo_pkg::NDates-1:0]    in_dates_i,
  input  logic [dpo_pkg::QCntW-1:0]               q_count_i,
  output logic                                    push_o,
  output dpo_pkg::q_entry_t                       push_data_o
);
  import dpo_pkg::*;

  typedef struct packed {
    date_t              dt;
    logic [YearW-1:0]   yy;
    logic [MonthW-1:0]  mi;
    logic [QuotW-1:0]   qy;
    logic [QuotW-1:0]   qyy;
    day_num_t           y365;
  } lane_t;

  logic                   s1_v_q, s2_v_q;
  lane_t [NDates-1:0]     s1_d, s1_q;
  q_entry_t               s2_d, s2_q;
  logic [QCntW:0]         used;
  logic                   in_fire;

  // room is reserved for every word still in the two stages
  assign used       = (QCntW+1)'(q_count_i) + (QCntW+1)'(s1_v_q) + (QCntW+1)'(s2_v_q);
  assign in_ready_o = used < (QCntW+1)'(QDepth);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    for (int i = 0; i < NDates; i++) begin
      s1_d[i].dt   = in_dates_i[i];
      if (in_dates_i[i].month > MonthFeb) begin
        s1_d[i].yy = in_dates_i[i].year;
        s1_d[i].mi = in_dates_i[i].month - MonthW'(3);
      end else begin
        s1_d[i].yy = in_dates_i[i].year - YearW'(1);
        s1_d[i].mi = in_dates_i[i].month + MonthW'(9);
      end
      s1_d[i].qy   = div100(in_dates_i[i].year);
      s1_d[i].qyy  = div100(s1_d[i].yy);
      s1_d[i].y365 = NumW'(s1_d[i].yy) * NumW'(365);
    end
  end

  always_comb begin
    logic ok;
    logic leap;
    s2_d.err = 1'b0;
    for (int i = 0; i < NDates; i++) begin
      leap = is_leap(s1_q[i].dt.year, s1_q[i].qy);
      ok   = (s1_q[i].dt.year >= YearMin) && (s1_q[i].dt.year <= YearMax) &&
             (s1_q[i].dt.month != MonthW'(0)) && (s1_q[i].dt.month <= MonthDec) &&
             (s1_q[i].dt.day != DayW'(0)) &&
             (s1_q[i].dt.day <= month_days(s1_q[i].dt.month, leap));
      if (!ok) begin
        s2_d.err = 1'b1;
      end
      s2_d.num[i] = s1_q[i].y365 + NumW'(s1_q[i].yy[YearW-1:2]) -
                    NumW'(s1_q[i].qyy) + NumW'(s1_q[i].qyy[QuotW-1:2]) +
                    NumW'(doy_offset(s1_q[i].mi)) + NumW'(s1_q[i].dt.day) - NumW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_fire;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  assign push_o      = s2_v_q;
  assign push_data_o = s2_q;

endmodule

[rtl/core/dpo_queue.sv]
// ----------------------------------------------------------------------------
// dpo_queue
// small fifo of decoded day numbers between the decoder and the back end
// ----------------------------------------------------------------------------
module dpo_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  dpo_pkg::q_entry_t          push_data_i,
  input  logic                       pop_i,
  output logic                       not_empty_o,
  output dpo_pkg::q_entry_t          head_o,
  output logic [dpo_pkg::QCntW-1:0]  count_o
);
  import dpo_pkg::*;

  q_entry_t [QDepth-1:0] mem_q;
  logic [QAw-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]      cnt_q, cnt_d;
  logic                  do_pop;

  assign do_pop = pop_i && (cnt_q != QCntW'(0));

  always_comb begin
    wr_d  = push_i ? wr_q + QAw'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QAw'(1) : rd_q;
    cnt_d = cnt_q + QCntW'(push_i) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign not_empty_o = cnt_q != QCntW'(0);
  assign head_o      = mem_q[rd_q];
  assign count_o     = cnt_q;

endmodule

[rtl/core/dpo_back.sv]
// ----------------------------------------------------------------------------
// dpo_back
// overlap stage: picks later start and earlier end, then counts the days
// ----------------------------------------------------------------------------
module dpo_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  dpo_pkg::q_entry_t           q_head_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dpo_pkg::CntW-1:0]    out_cnt_o,
  output logic                        out_err_o
);
  import dpo_pkg::*;

  logic                b1_v_q, o_v_q;
  day_num_t            lo_q, hi_q, lo_d, hi_d;
  logic                ok_q, ok_d, err_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                o_err_q;
  logic                o_ready, b1_ready, b1_fire;

  assign o_ready  = !o_v_q || out_ready_i;
  assign b1_ready = !b1_v_q || o_ready;
  assign q_pop_o  = q_valid_i && b1_ready;
  assign b1_fire  = b1_v_q && o_ready;

  always_comb begin
    lo_d = (q_head_i.num[0] > q_head_i.num[2]) ? q_head_i.num[0] : q_head_i.num[2];
    hi_d = (q_head_i.num[1] < q_head_i.num[3]) ? q_head_i.num[1] : q_head_i.num[3];
    ok_d = !q_head_i.err && (q_head_i.num[1] >= q_head_i.num[0]) &&
           (q_head_i.num[3] >= q_head_i.num[2]);
  end

  always_comb begin
    day_num_t diff;
    diff  = hi_q - lo_q + NumW'(1);
    cnt_d = (ok_q && (hi_q >= lo_q)) ? diff[CntW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_v_q <= q_valid_i;
      end
      if (o_ready) begin
        o_v_q <= b1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      ok_q  <= ok_d;
      err_q <= q_head_i.err;
    end
    if (b1_fire) begin
      cnt_q   <= cnt_d;
      o_err_q <= err_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_cnt_o   = cnt_q;
  assign out_err_o   = o_err_q;

endmodule

[rtl/core/date_period_overlap_days_unit.sv]
// ----------------------------------------------------------------------------
// date_period_overlap_days_unit
// days shared by two gregorian date periods, both ends counted
// ----------------------------------------------------------------------------
// throughput: one period pair per cycle unless the output stalls; the 4-entry
//   queue between the two-stage decoder and the overlap stages lets either
//   side stall alone
// reset: clears valid flags and queue pointers; data registers keep content
module date_period_overlap_days_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] a_start_year, [15:12] a_start_month, [20:16] a_start_day,
  // [32:21] a_end_year, [36:33] a_end_month, [41:37] a_end_day,
  // [53:42] b_start_year, [57:54] b_start_month, [62:58] b_start_day,
  // [74:63] b_end_year, [78:75] b_end_month, [83:79] b_end_day, [87:84] zero
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [19:0] overlap_days, [23:20] zero
  output logic [23:0] m_axis_tdata,
  // [0] date_error
  output logic [0:0]  m_axis_tuser
);
  import dpo_pkg::*;

  localparam int unsigned DateW = YearW + MonthW + DayW;

  date_t [NDates-1:0] dates;
  logic               push, q_valid, q_pop;
  q_entry_t           push_data, q_head;
  logic [QCntW-1:0]   q_count;
  logic [CntW-1:0]    cnt;
  logic               err;

  // each date packs year low, then month, then day
  always_comb begin
    for (int i = 0; i < NDates; i++) begin
      dates[i].year  = s_axis_tdata[i*DateW +: YearW];
      dates[i].month = s_axis_tdata[i*DateW + YearW +: MonthW];
      dates[i].day   = s_axis_tdata[i*DateW + YearW + MonthW +: DayW];
    end
  end

  dpo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_dates_i  (dates),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dpo_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .not_empty_o (q_valid),
    .head_o      (q_head),
    .count_o     (q_count)
  );

  dpo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_head_i    (q_head),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_cnt_o   (cnt),
    .out_err_o   (err)
  );

  assign m_axis_tdata = {4'b0000, cnt};
  assign m_axis_tuser = err;

endmodule

[dv/tb_date_period_overlap_days_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_period_overlap_days_unit
// stream-level check of the day count shared by two gregorian periods
// ----------------------------------------------------------------------------
// Every period pair taken by the unit is decoded and its overlap worked out
// here from day numbers; the outgoing words are compared in order with that
// count and the invalid-date flag. A directed set covers the calendar edges,
// then random pairs run under four idle/stall mixes on both stream sides.
// ----------------------------------------------------------------------------
module tb_date_period_overlap_days_unit;
  import dpo_pkg::*;

  localparam int unsigned ClkHalf    = 6;
  localparam int unsigned ResetCyc   = 6;
  localparam int unsigned PhaseItems = 175;
  localparam int unsigned DrainCyc   = 20;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned QuietAfter = 30;

  typedef struct packed {
    logic [CntW-1:0] days;
    logic            bad;
  } overlap_t;

  class overlap_ledger;
    overlap_t expected_overlaps[$];
    int unsigned errors;
    int unsigned n_pairs;
    int unsigned n_bad;
    int unsigned n_shared;

    static function bit leap_yr(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    static function int unsigned month_len(int unsigned y, int unsigned m);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return leap_yr(y) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    static function bit date_valid(date_t dt);
      if (dt.year < YearMin || dt.year > YearMax) return 1'b0;
      if (dt.month < 1 || dt.month > MonthDec) return 1'b0;
      return dt.day >= 1 && dt.day <= month_len(dt.year, dt.month);
    endfunction

    // day count from a fixed epoch, years taken as starting in march
    static function day_num_t day_index(date_t dt);
      int unsigned yy, mm;
      if (dt.month > MonthFeb) begin
        yy = dt.year;
        mm = dt.month - 3;
      end else begin
        yy = dt.year - 1;
        mm = dt.month + 9;
      end
      return day_num_t'(365 * yy + yy / 4 - yy / 100 + yy / 400
                        + (153 * mm + 2) / 5 + dt.day - 1);
    endfunction

    static function overlap_t shared_days(date_t dts[NDates]);
      overlap_t r;
      day_num_t n[NDates];
      day_num_t lo, hi;
      r = '0;
      foreach (dts[i]) if (!date_valid(dts[i])) r.bad = 1'b1;
      if (r.bad) return r;
      foreach (dts[i]) n[i] = day_index(dts[i]);
      lo = (n[0] > n[2]) ? n[0] : n[2];
      hi = (n[1] < n[3]) ? n[1] : n[3];
      if (n[1] >= n[0] && n[3] >= n[2] && hi >= lo) r.days = CntW'(hi - lo + 1);
      return r;
    endfunction

    function void note_periods(logic [87:0] w);
      date_t dts[NDates];
      overlap_t e;
      for (int i = 0; i < NDates; i++) begin
        dts[i].year  = w[i*21 +: YearW];
        dts[i].month = w[i*21+12 +: MonthW];
        dts[i].day   = w[i*21+16 +: DayW];
      end
      e = shared_days(dts);
      expected_overlaps.push_back(e);
      n_pairs++;
      if (e.bad) n_bad++;
      if (e.days != 0) n_shared++;
    endfunction

    task report(string msg);
      // keep the log readable when everything is off
      if (errors < QuietAfter) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_overlap(logic [CntW-1:0] days, logic bad);
      overlap_t e;
      if (expected_overlaps.size() == 0) begin
        report($sformatf("unexpected word days=%0d err=%0b", days, bad));
        return;
      end
      e = expected_overlaps.pop_front();
      if (days !== e.days)
        report($sformatf("overlap_days got %0d want %0d", days, e.days));
      if (bad !== e.bad)
        report($sformatf("date_error got %0b want %0b", bad, e.bad));
    endtask

    function int unsigned pending();
      return expected_overlaps.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  overlap_ledger ledger;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int unsigned   cycle_cnt;

  date_period_overlap_days_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #ClkHalf;
    clk_i = 1'b0;
    #ClkHalf;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) ledger.note_periods(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      ledger.check_overlap(m_axis_tdata[CntW-1:0], m_axis_tuser[0]);
  end

  function automatic date_t mk(int unsigned y, int unsigned m, int unsigned d);
    date_t dt;
    dt.year  = YearW'(y);
    dt.month = MonthW'(m);
    dt.day   = DayW'(d);
    return dt;
  endfunction

  function automatic date_t rand_valid_date(int unsigned ylo, int unsigned yhi);
    int unsigned y, m;
    y = $urandom_range(yhi, ylo);
    m = $urandom_range(12, 1);
    return mk(y, m, $urandom_range(overlap_ledger::month_len(y, m), 1));
  endfunction

  // one date made invalid through its year, month or day
  function automatic date_t break_date(date_t dt);
    date_t r;
    int unsigned len;
    r = dt;
    case ($urandom_range(2, 0))
      0: r.year = $urandom_range(1) ? YearW'($urandom_range(1000, 0))
                                     : YearW'($urandom_range(4095, 3000));
      1: r.month = $urandom_range(1) ? MonthW'(0) : MonthW'($urandom_range(15, 13));
      default: begin
        len = overlap_ledger::month_len(r.year, r.month);
        r.day = (len == 31 || $urandom_range(1)) ? DayW'(0)
                                                  : DayW'($urandom_range(31, len + 1));
      end
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [87:0] w);
    while ($urandom_range(99, 0) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_pair(input date_t a0, input date_t a1, input date_t b0,
                           input date_t b1);
    send_word({4'b0, b1.day, b1.month, b1.year, b0.day, b0.month, b0.year,
               a1.day, a1.month, a1.year, a0.day, a0.month, a0.year});
  endtask

  task automatic send_random_pair();
    date_t dts[NDates];
    int unsigned sel, y0, y1, span;
    sel = $urandom_range(99, 0);
    if (sel < 12) begin
      // raw noise across every field bit
      send_word({4'b0, 20'($urandom), 32'($urandom), 32'($urandom)});
      return;
    end
    span = $urandom_range(99, 0);
    if (span < 65)      span = 0;
    else if (span < 88) span = $urandom_range(3, 1);
    else                span = $urandom_range(1998, 4);
    case ($urandom_range(9, 0))
      0:       y0 = YearMin;
      1:       y0 = (YearMax > span) ? YearMax - span : YearMin;
      default: y0 = $urandom_range(YearMax, YearMin);
    endcase
    y1 = (y0 + span > YearMax) ? YearMax : y0 + span;
    foreach (dts[i]) dts[i] = rand_valid_date(y0, y1);
    if (sel < 20) begin
      sel = $urandom_range(NDates - 1, 0);
      dts[sel] = break_date(dts[sel]);
    end
    send_pair(dts[0], dts[1], dts[2], dts[3]);
  endtask

  task automatic run_directed();
    date_t first, last;
    first = mk(1001, 1, 1);
    last  = mk(2999, 12, 31);
    send_pair(first, last, first, last);
    send_pair(mk(2024, 6, 15), mk(2024, 6, 15), mk(2024, 6, 15), mk(2024, 6, 15));
    // period a ends before it starts
    send_pair(mk(2020, 5, 1), mk(2020, 4, 30), first, last);
    send_pair(mk(1500, 1, 1), mk(1500, 12, 31), mk(1600, 1, 1), mk(1700, 1, 1));
    send_pair(mk(1000, 12, 31), mk(1200, 1, 1), mk(1100, 1, 1), mk(1150, 1, 1));
    send_pair(mk(2900, 1, 1), mk(2999, 1, 1), mk(2950, 1, 1), mk(3000, 1, 1));
    send_word('0);
    send_word({4'b0, {84{1'b1}}});
    send_pair(mk(2000, 0, 1), mk(2000, 5, 1), mk(2000, 1, 1), mk(2000, 2, 1));
    send_pair(mk(2000, 1, 1), mk(2000, 13, 1), mk(2000, 1, 1), mk(2000, 2, 1));
    send_pair(mk(2000, 1, 1), mk(2000, 3, 1), mk(2000, 1, 0), mk(2000, 2, 1));
    send_pair(mk(2000, 1, 1), mk(2000, 3, 1), mk(2000, 1, 1), mk(2000, 4, 31));
    // leap day in a 400 year, a plain century, a plain leap year, a common year
    send_pair(mk(2000, 2, 1), mk(2000, 2, 29), mk(2000, 2, 29), mk(2000, 3, 10));
    send_pair(mk(1900, 2, 1), mk(1900, 2, 29), mk(1900, 2, 1), mk(1900, 3, 1));
    send_pair(mk(2004, 2, 29), mk(2004, 3, 1), mk(2004, 1, 1), mk(2004, 12, 31));
    send_pair(mk(2001, 2, 1), mk(2001, 3, 1), mk(2001, 2, 29), mk(2001, 3, 1));
    send_pair(mk(1999, 7, 4), mk(2001, 2, 28), mk(2000, 1, 1), mk(2003, 1, 1));
    send_pair(mk(1800, 1, 1), mk(2200, 12, 31), mk(1900, 2, 28), mk(1900, 3, 1));
    // one shared day where a ends as b begins
    send_pair(mk(2010, 1, 1), mk(2010, 12, 31), mk(2010, 12, 31), mk(2011, 6, 1));
    send_pair(mk(1999, 12, 31), mk(2000, 1, 1), mk(1999, 12, 30), mk(2000, 1, 2));
    send_pair(first, first, first, last);
    send_pair(last, last, first, last);
  endtask

  initial begin
    ledger        = new();
    cycle_cnt     = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (ResetCyc) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      repeat (PhaseItems) send_random_pair();
    end
    s_axis_tvalid <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);

    $display("checked %0d period pairs: %0d with an invalid date, %0d sharing days",
             ledger.n_pairs, ledger.n_bad, ledger.n_shared);
    $display("ran free, sender-idle, receiver-stall and mixed traffic; %0d mismatches",
             ledger.errors);
    if (ledger.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/dpo_pkg.sv
rtl/core/dpo_front.sv
rtl/core/dpo_queue.sv
rtl/core/dpo_back.sv
rtl/core/date_period_overlap_days_unit.sv
dv/tb_date_period_overlap_days_unit.sv
